// ===== hw/rtl/level_crossing_sampler_defines.svh =====
// Assertion macros shared by the level-crossing sampler RTL.
`ifndef LEVEL_CROSSING_SAMPLER_DEFINES_SVH
`define LEVEL_CROSSING_SAMPLER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define LCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lcs_pkg.sv =====
// Types and constants of the level-crossing sampler.
package lcs_pkg;

    localparam int LEVEL_REGS  = 4;
    localparam int SAMPLE_W    = 16;
    localparam int TIME_W      = 32;
    localparam int INDEX_W     = 2;
    localparam int COUNT_W     = 3;
    localparam int SKIP_W      = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CFG_LEVEL_0     = 3'd0,
        CFG_LEVEL_1     = 3'd1,
        CFG_LEVEL_2     = 3'd2,
        CFG_LEVEL_3     = 3'd3,
        CFG_LEVEL_COUNT = 3'd4,
        CFG_SKIP        = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [TIME_W-1:0]          sample_time;
    } t_sample_beat;

    typedef struct packed {
        logic [TIME_W-1:0]          crossing_time;
        logic signed [SAMPLE_W-1:0] crossing_level;
        logic [INDEX_W-1:0]         crossing_index;
    } t_crossing_beat;

    typedef struct packed {
        logic [LEVEL_REGS-1:0][SAMPLE_W-1:0] level;
        logic [COUNT_W-1:0]                  level_count;
        logic [SKIP_W-1:0]                   skip_setting;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]     sample_time;
        logic [LEVEL_REGS-1:0] cross_mask;
    } t_cross_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== hw/rtl/lcs_front.sv =====
// Front end: accept samples, find crossed levels, queue crossing items.
module lcs_front #(
    parameter int NUM_LEVELS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcs_pkg::t_cfg         i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  lcs_pkg::t_sample_beat i_in_beat,
    input  lcs_pkg::t_queue_status i_q_status,
    output logic                  o_push,
    output lcs_pkg::t_cross_item  o_item
);
    import lcs_pkg::*;

    localparam int ACT_MAX = (NUM_LEVELS < LEVEL_REGS) ? NUM_LEVELS : LEVEL_REGS;

    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] n_prev;
    logic                       r_have_prev;
    logic                       n_have_prev;
    logic                       w_accept;
    logic [COUNT_W-1:0]         w_active;
    logic [LEVEL_REGS-1:0]      w_mask;

    assign o_in_stall = i_q_status.full;
    assign w_accept   = i_in_valid && !i_q_status.full;

    always_comb begin
        if (i_cfg.level_count > COUNT_W'(ACT_MAX)) begin
            w_active = COUNT_W'(ACT_MAX);
        end else begin
            w_active = i_cfg.level_count;
        end
    end

    always_comb begin
        logic signed [SAMPLE_W-1:0] lv;
        logic signed [SAMPLE_W-1:0] cur;
        cur = i_in_beat.sample_value;
        for (int k = 0; k < LEVEL_REGS; k++) begin
            lv = $signed(i_cfg.level[k]);
            w_mask[k] = (COUNT_W'(k) < w_active) &&
                        (((r_prev < lv) && (lv < cur)) || ((cur < lv) && (lv < r_prev)));
        end
    end

    assign o_push             = w_accept && r_have_prev && (w_mask != '0);
    assign o_item.sample_time = i_in_beat.sample_time;
    assign o_item.cross_mask  = w_mask;

    always_comb begin
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        if (w_accept) begin
            n_prev      = i_in_beat.sample_value;
            n_have_prev = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
        end
    end

endmodule

// ===== hw/rtl/lcs_queue.sv =====
// Short queue between the front end and the back end.
`include "level_crossing_sampler_defines.svh"
module lcs_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  lcs_pkg::t_cross_item   i_item,
    input  logic                   i_pop,
    output lcs_pkg::t_cross_item   o_item,
    output lcs_pkg::t_queue_status o_status
);
    import lcs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cross_item        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `LCS_ASSERT_NOW(a_no_push_full, i_push, !o_status.full, "push into full queue")
    `LCS_ASSERT_NOW(a_no_pop_empty, i_pop, !o_status.empty, "pop from empty queue")
    `LCS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

// ===== hw/rtl/lcs_back.sv =====
// Back end: apply the skip counter and drive the output beat register.
`include "level_crossing_sampler_defines.svh"
module lcs_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lcs_pkg::t_cfg           i_cfg,
    input  lcs_pkg::t_queue_status  i_q_status,
    input  lcs_pkg::t_cross_item    i_item,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output lcs_pkg::t_crossing_beat o_out_beat
);
    import lcs_pkg::*;

    logic [SKIP_W-1:0]  r_skip;
    logic [SKIP_W-1:0]  n_skip;
    logic               r_out_valid;
    t_crossing_beat     r_out_beat;
    logic               w_emit;
    logic [INDEX_W-1:0] w_index;
    logic [COUNT_W-1:0] w_count;

    assign o_pop       = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_comb begin
        w_emit  = 1'b0;
        w_index = '0;
        w_count = '0;
        for (int k = 0; k < LEVEL_REGS; k++) begin
            if (i_item.cross_mask[k]) begin
                if (!w_emit && ({{(SKIP_W-COUNT_W){1'b0}}, w_count} == r_skip)) begin
                    w_emit  = 1'b1;
                    w_index = INDEX_W'(k);
                end
                w_count = w_count + 1'b1;
            end
        end
    end

    always_comb begin
        n_skip = r_skip;
        if (o_pop) begin
            if (w_emit) begin
                n_skip = i_cfg.skip_setting;
            end else begin
                n_skip = r_skip - {{(SKIP_W-COUNT_W){1'b0}}, w_count};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_skip <= n_skip;
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_out_beat.crossing_time  <= i_item.sample_time;
            r_out_beat.crossing_level <= $signed(i_cfg.level[w_index]);
            r_out_beat.crossing_index <= w_index;
        end
    end

    `LCS_ASSERT_NOW(a_hold_on_stall, r_out_valid && i_out_stall, !o_pop,
        "queue popped while output beat stalled")
    `LCS_ASSERT_NEXT(a_reload, o_pop && w_emit, r_skip == $past(i_cfg.skip_setting),
        "skip counter not reloaded after emit")
    `LCS_ASSERT_NEXT(a_no_wrap, o_pop && !w_emit, r_skip <= $past(r_skip),
        "skip counter wrapped")

endmodule

// ===== hw/rtl/level_crossing_sampler.sv =====
// Top level of the level-crossing sampler: configuration registers and wiring.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries one sample beat:
//   a signed 16-bit value and a 32-bit timestamp. Output channel (o_out_valid /
//   i_out_stall / o_out_beat) carries one crossing beat: timestamp, level value
//   and level index. A beat moves at a clock edge with valid high, stall low.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
//   the block is idle: indexes 0..3 levels, 4 level count, 5 skip setting.
//   Throughput: one sample per cycle while the queue is not full. The front
//   compares a sample against all levels in parallel; the back applies the skip
//   counter to one queued item per cycle while the output register is not stalled.
//   A crossing beat passes the queue register, then the output register. Samples
//   with no crossing, and the first sample after reset, produce no beat.
//   Reset: clears levels, level count, skip setting and counter, stored sample.
//   Output stall: the output register holds; the two-entry queue absorbs beats
//   and o_in_stall rises only when the queue is full.
module level_crossing_sampler #(
    parameter int NUM_LEVELS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  lcs_pkg::t_sample_beat   i_in_beat,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output lcs_pkg::t_crossing_beat o_out_beat,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data
);
    import lcs_pkg::*;

    t_cfg          r_cfg;
    t_cfg          n_cfg;
    t_queue_status w_q_status;
    t_cross_item   w_push_item;
    t_cross_item   w_pop_item;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEVEL_0:     n_cfg.level[0]     = i_cfg_data;
                CFG_LEVEL_1:     n_cfg.level[1]     = i_cfg_data;
                CFG_LEVEL_2:     n_cfg.level[2]     = i_cfg_data;
                CFG_LEVEL_3:     n_cfg.level[3]     = i_cfg_data;
                CFG_LEVEL_COUNT: n_cfg.level_count  = i_cfg_data[COUNT_W-1:0];
                CFG_SKIP:        n_cfg.skip_setting = i_cfg_data[SKIP_W-1:0];
                default:         n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    lcs_front #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    lcs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_pop_item),
        .o_status (w_q_status)
    );

    lcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (w_q_status),
        .i_item      (w_pop_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
